### design/afdc_pkg.sv
// ----------------------------------------------------------------------------
// afdc_pkg - shared definitions for the audio fade / dehiss chain
// Field widths, register indices, reset values, FSM states and helpers.
// ----------------------------------------------------------------------------
package afdc_pkg;

    localparam int COUNT_WIDTH_DEF = 24;

    localparam int SAMPLE_W = 16;
    localparam int SLOT_W   = 32;
    localparam int TOTAL_W  = 24;
    localparam int FADE_W   = 16;
    localparam int COEFF_W  = 15;
    localparam int LPDIV_W  = 8;
    localparam int THR_W    = 15;
    localparam int Q15_FRAC = 15;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // serial arithmetic units
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 16;
    localparam int DIV_N_W   = 48;
    localparam int DIV_D_W   = 16;
    localparam int DIV_LEN_W = $clog2(DIV_N_W + 1);

    localparam logic [DIV_D_W-1:0] Q15_ONE = 16'd32767;

    // register indices
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SAMPLES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEANUP_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DC_COEFF       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LP_DIVISOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD = 3'd5;

    // reset values
    localparam logic [TOTAL_W-1:0] TOTAL_RESET   = 24'd0;
    localparam logic [FADE_W-1:0]  FADE_RESET    = 16'd441;
    localparam logic               CLEANUP_RESET = 1'b1;
    localparam logic [COEFF_W-1:0] DC_RESET      = 15'd32604;
    localparam logic [LPDIV_W-1:0] LPDIV_RESET   = 8'd4;
    localparam logic [THR_W-1:0]   THR_RESET     = 15'd80;

    typedef struct packed {
        logic                 start;
        logic [DIV_LEN_W-1:0] len;
    } div_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SELECT,
        ST_GAIN_DIV,
        ST_FADE_MUL,
        ST_FADE_DIV,
        ST_POST_FADE,
        ST_HP_MUL,
        ST_HP_DIV,
        ST_HP_SUM,
        ST_LP_START,
        ST_LP_DIV,
        ST_LP_SUM,
        ST_GATE,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -35'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = $signed(v[31:0]);
        end
        return r;
    endfunction

endpackage

### design/afdc_mul.sv
// ----------------------------------------------------------------------------
// afdc_mul - bit-serial unsigned multiplier
// Shift-add, one multiplier bit per cycle; done pulses when product is final.
// ----------------------------------------------------------------------------
module afdc_mul (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [afdc_pkg::MUL_A_W-1:0]                  a,
    input  logic [afdc_pkg::MUL_B_W-1:0]                  b,
    output logic                                          done,
    output logic [afdc_pkg::MUL_A_W+afdc_pkg::MUL_B_W-1:0] product
);
    import afdc_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_A_W-1:0] hi_reg;
    logic [MUL_B_W-1:0] lo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_A_W-1:0] addend;
    logic [MUL_A_W:0]   sum;

    assign addend = lo_reg[0] ? a_reg : '0;
    assign sum    = {1'b0, hi_reg} + {1'b0, addend};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MUL_B_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand / accumulator shift chain
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[MUL_A_W:1];
            lo_reg <= {sum[0], lo_reg[MUL_B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

### design/afdc_div.sv
// ----------------------------------------------------------------------------
// afdc_div - bit-serial restoring divider
// Dividend is left-aligned; len quotient bits are produced, one per cycle.
// ----------------------------------------------------------------------------
module afdc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  afdc_pkg::div_req_t            req,
    input  logic [afdc_pkg::DIV_N_W-1:0]  dividend,
    input  logic [afdc_pkg::DIV_D_W-1:0]  divisor,
    output logic                          done,
    output logic [afdc_pkg::DIV_N_W-1:0]  quotient
);
    import afdc_pkg::*;

    logic [DIV_N_W-1:0]   num_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_LEN_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    assign trial = {rem_reg, num_reg[DIV_N_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.len;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_LEN_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
            num_reg <= {num_reg[DIV_N_W-2:0], 1'b0};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/audio_fade_dehiss_chain_core.sv
// ----------------------------------------------------------------------------
// audio_fade_dehiss_chain_core - clip edge fade with DC blocker, low-pass,
// noise gate and clamp, one mono sample in, one stereo slot pair out.
// Throughput: one item at a time; a new sample is accepted only once the last
// result is in the output register. Processing time is set by the single
// bit-serial divider (one quotient bit per cycle) and the bit-serial
// multiplier.
// Reset: rst_n clears index, filter state, FSM and output valid and loads
// the register defaults.
// ----------------------------------------------------------------------------
module audio_fade_dehiss_chain_core #(
    parameter int COUNT_WIDTH = afdc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [afdc_pkg::SAMPLE_W-1:0]       s_axis_tdata,   // [15:0] sample_in
    input  logic [0:0]                          s_axis_tuser,   // [0] first_of_clip
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [2*afdc_pkg::SLOT_W-1:0]       m_axis_tdata,   // [31:0] left_slot,
                                                                // [63:32] right_slot
    output logic                                m_axis_tlast,   // clip_end
    // register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [afdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [afdc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import afdc_pkg::*;

    // common width for comparing the index against the clip length
    localparam int IW = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;
    localparam int GAIN_NUM_W = FADE_W + Q15_FRAC;   // n * 32767
    localparam int FPROD_W    = SAMPLE_W + Q15_FRAC; // |s| * gain
    localparam int HPROD_W    = SLOT_W + COEFF_W;    // |y_prev| * coeff
    localparam int LPMAG_W    = SLOT_W + 1;          // |y_hp - z_prev|

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [TOTAL_W-1:0] total_samples_reg;
    logic [FADE_W-1:0]  fade_length_reg;
    logic               cleanup_enable_reg;
    logic [COEFF_W-1:0] dc_coeff_reg;
    logic [LPDIV_W-1:0] lp_divisor_reg;
    logic [THR_W-1:0]   gate_threshold_reg;

    logic [COUNT_WIDTH-1:0] sample_index_reg, sample_index_next;
    logic [COUNT_WIDTH-1:0] idx_reg, idx_next;
    logic [SAMPLE_W-1:0]    s_reg, s_next;

    logic               bypass_reg, bypass_next;
    logic               past_reg, past_next;
    logic               head_reg, head_next;
    logic               clip_end_reg, clip_end_next;
    logic [TOTAL_W-1:0] rem_reg, rem_next;
    logic               neg_reg, neg_next;

    logic signed [SAMPLE_W-1:0] faded_reg, faded_next;
    logic signed [SLOT_W:0]     term_reg, term_next;
    logic signed [SLOT_W+1:0]   step_reg, step_next;
    logic signed [SAMPLE_W-1:0] result_reg, result_next;

    logic signed [SAMPLE_W-1:0] hp_prev_input_reg, hp_prev_input_next;
    logic signed [SLOT_W-1:0]   hp_prev_output_reg, hp_prev_output_next;
    logic signed [SLOT_W-1:0]   lp_prev_output_reg, lp_prev_output_next;

    logic                       out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]        out_sample_reg, out_sample_next;
    logic                       out_last_reg, out_last_next;

    // ------------------------------------------------------------------------
    // Serial units
    // ------------------------------------------------------------------------
    logic                          mul_start;
    logic [MUL_A_W-1:0]            mul_a;
    logic [MUL_B_W-1:0]            mul_b;
    logic                          mul_done;
    logic [MUL_A_W+MUL_B_W-1:0]    mul_product;

    div_req_t                      div_req;
    logic [DIV_N_W-1:0]            div_dividend;
    logic [DIV_D_W-1:0]            div_divisor;
    logic                          div_done;
    logic [DIV_N_W-1:0]            div_quotient;

    afdc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    afdc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // ------------------------------------------------------------------------
    // Register writes (taken any time, only meaningful while idle)
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_samples_reg  <= TOTAL_RESET;
            fade_length_reg    <= FADE_RESET;
            cleanup_enable_reg <= CLEANUP_RESET;
            dc_coeff_reg       <= DC_RESET;
            lp_divisor_reg     <= LPDIV_RESET;
            gate_threshold_reg <= THR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TOTAL_SAMPLES:  total_samples_reg  <= cfg_data[TOTAL_W-1:0];
                REG_FADE_LENGTH:    fade_length_reg    <= cfg_data[FADE_W-1:0];
                REG_CLEANUP_ENABLE: cleanup_enable_reg <= cfg_data[0];
                REG_DC_COEFF:       dc_coeff_reg       <= cfg_data[COEFF_W-1:0];
                REG_LP_DIVISOR:     lp_divisor_reg     <= cfg_data[LPDIV_W-1:0];
                REG_GATE_THRESHOLD: gate_threshold_reg <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------------
    // index for the incoming item: first-of-clip restarts at zero
    logic [COUNT_WIDTH-1:0] idx_cur, idx_inc;
    assign idx_cur = s_axis_tuser[0] ? '0 : sample_index_reg;
    assign idx_inc = (&idx_cur) ? idx_cur : idx_cur + 1'b1;   // saturate

    // fade window checks
    logic [IW-1:0]      idx_ext, tot_ext;
    logic               fade_bypass, past_end, in_head, clip_hit;
    logic [TOTAL_W-1:0] rem_cur;
    assign idx_ext     = IW'(idx_reg);
    assign tot_ext     = IW'(total_samples_reg);
    assign fade_bypass = (total_samples_reg == '0) || (fade_length_reg == '0);
    assign past_end    = (idx_ext >= tot_ext);
    assign in_head     = (idx_ext < IW'(fade_length_reg));
    assign rem_cur     = total_samples_reg - idx_ext[TOTAL_W-1:0];
    assign clip_hit    = (total_samples_reg != '0) && (idx_ext == tot_ext - IW'(1));

    // gain numerator: the smaller ramp position gives the smaller gain
    logic                  in_tail;
    logic [TOTAL_W-1:0]    rem_m1;
    logic [FADE_W-1:0]     head_n, tail_n, n_sel;
    logic [GAIN_NUM_W-1:0] gain_num;
    assign in_tail  = (rem_reg <= TOTAL_W'(fade_length_reg));
    assign rem_m1   = rem_reg - 1'b1;
    assign head_n   = idx_reg[FADE_W-1:0];
    assign tail_n   = rem_m1[FADE_W-1:0];
    assign n_sel    = (head_reg && in_tail) ? ((head_n < tail_n) ? head_n : tail_n)
                    : (head_reg ? head_n : tail_n);
    assign gain_num = {n_sel, {Q15_FRAC{1'b0}}} - GAIN_NUM_W'(n_sel);

    // sign / magnitude views
    logic [SAMPLE_W:0]   s_ext, s_mag;
    logic [SLOT_W-1:0]   hp_mag;
    assign s_ext  = {s_reg[SAMPLE_W-1], s_reg};
    assign s_mag  = s_reg[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - s_ext) : s_ext;
    assign hp_mag = hp_prev_output_reg[SLOT_W-1] ? (SLOT_W'(0) - $unsigned(hp_prev_output_reg))
                                                  : $unsigned(hp_prev_output_reg);

    // quotient back to signed values
    logic [SAMPLE_W-1:0] q16;
    logic [SLOT_W:0]     q33;
    logic [SLOT_W+1:0]   q34;
    assign q16 = div_quotient[SAMPLE_W-1:0];
    assign q33 = {1'b0, div_quotient[SLOT_W-1:0]};
    assign q34 = {1'b0, div_quotient[LPMAG_W-1:0]};

    // DC blocker sum
    logic signed [SLOT_W+2:0] hp_sum;
    assign hp_sum = (SLOT_W+3)'(faded_reg) - (SLOT_W+3)'(hp_prev_input_reg)
                  + (SLOT_W+3)'(term_reg);

    // low-pass difference and update
    logic signed [SLOT_W:0]   lp_diff;
    logic [LPMAG_W-1:0]       lp_mag;
    logic [DIV_D_W-1:0]       lp_div;
    logic signed [SLOT_W+2:0] lp_sum;
    assign lp_diff = (SLOT_W+1)'(hp_prev_output_reg) - (SLOT_W+1)'(lp_prev_output_reg);
    assign lp_mag  = lp_diff[SLOT_W] ? (LPMAG_W'(0) - $unsigned(lp_diff)) : $unsigned(lp_diff);
    assign lp_div  = (lp_divisor_reg == '0) ? DIV_D_W'(1) : DIV_D_W'(lp_divisor_reg);
    assign lp_sum  = (SLOT_W+3)'(lp_prev_output_reg) + (SLOT_W+3)'(step_reg);

    // gate and clamp on the stored low-pass output
    logic signed [SLOT_W:0]     thr_s, y_ext;
    logic                       gate_hit;
    logic signed [SAMPLE_W-1:0] gated;
    assign thr_s    = $signed({{(SLOT_W+1-THR_W){1'b0}}, gate_threshold_reg});
    assign y_ext    = (SLOT_W+1)'(lp_prev_output_reg);
    assign gate_hit = (y_ext > -thr_s) && (y_ext < thr_s);
    always_comb
    begin
        if (gate_hit)
        begin
            gated = '0;
        end
        else if (y_ext > 33'sd32767)
        begin
            gated = 16'sh7FFF;
        end
        else if (y_ext < -33'sd32768)
        begin
            gated = 16'sh8000;
        end
        else
        begin
            gated = $signed(lp_prev_output_reg[SAMPLE_W-1:0]);
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            sample_index_reg   <= '0;
            hp_prev_input_reg  <= '0;
            hp_prev_output_reg <= '0;
            lp_prev_output_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            sample_index_reg   <= sample_index_next;
            hp_prev_input_reg  <= hp_prev_input_next;
            hp_prev_output_reg <= hp_prev_output_next;
            lp_prev_output_reg <= lp_prev_output_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // working payload, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        s_reg          <= s_next;
        bypass_reg     <= bypass_next;
        past_reg       <= past_next;
        head_reg       <= head_next;
        clip_end_reg   <= clip_end_next;
        rem_reg        <= rem_next;
        neg_reg        <= neg_next;
        faded_reg      <= faded_next;
        term_reg       <= term_next;
        step_reg       <= step_next;
        result_reg     <= result_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next          = state_reg;
        sample_index_next   = sample_index_reg;
        idx_next            = idx_reg;
        s_next              = s_reg;
        bypass_next         = bypass_reg;
        past_next           = past_reg;
        head_next           = head_reg;
        clip_end_next       = clip_end_reg;
        rem_next            = rem_reg;
        neg_next            = neg_reg;
        faded_next          = faded_reg;
        term_next           = term_reg;
        step_next           = step_reg;
        result_next         = result_reg;
        hp_prev_input_next  = hp_prev_input_reg;
        hp_prev_output_next = hp_prev_output_reg;
        lp_prev_output_next = lp_prev_output_reg;
        out_valid_next      = out_valid_reg;
        out_sample_next     = out_sample_reg;
        out_last_next       = out_last_reg;

        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_req      = '0;
        div_dividend = '0;
        div_divisor  = '0;

        // output register drains independently of the sequencer
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    s_next            = s_axis_tdata;
                    idx_next          = idx_cur;
                    sample_index_next = idx_inc;
                    if (s_axis_tuser[0])
                    begin
                        hp_prev_input_next  = '0;
                        hp_prev_output_next = '0;
                        lp_prev_output_next = '0;
                    end
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                bypass_next   = fade_bypass;
                past_next     = past_end;
                head_next     = in_head;
                rem_next      = rem_cur;
                clip_end_next = clip_hit;
                state_next    = ST_SELECT;
            end

            ST_SELECT:
            begin
                if (bypass_reg)
                begin
                    faded_next = $signed(s_reg);
                    state_next = ST_POST_FADE;
                end
                else if (past_reg)
                begin
                    faded_next = '0;
                    state_next = ST_POST_FADE;
                end
                else if (!head_reg && !in_tail)
                begin
                    // full gain is exact
                    faded_next = $signed(s_reg);
                    state_next = ST_POST_FADE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.len   = DIV_LEN_W'(GAIN_NUM_W);
                    div_dividend  = {gain_num, {(DIV_N_W-GAIN_NUM_W){1'b0}}};
                    div_divisor   = fade_length_reg;
                    state_next    = ST_GAIN_DIV;
                end
            end

            ST_GAIN_DIV:
            begin
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(s_mag);
                    mul_b      = div_quotient[MUL_B_W-1:0];
                    neg_next   = s_reg[SAMPLE_W-1];
                    state_next = ST_FADE_MUL;
                end
            end

            ST_FADE_MUL:
            begin
                if (mul_done)
                begin
                    div_req.start = 1'b1;
                    div_req.len   = DIV_LEN_W'(FPROD_W);
                    div_dividend  = {mul_product[FPROD_W-1:0], {(DIV_N_W-FPROD_W){1'b0}}};
                    div_divisor   = Q15_ONE;
                    state_next    = ST_FADE_DIV;
                end
            end

            ST_FADE_DIV:
            begin
                if (div_done)
                begin
                    faded_next = neg_reg ? $signed(SAMPLE_W'(0) - q16) : $signed(q16);
                    state_next = ST_POST_FADE;
                end
            end

            ST_POST_FADE:
            begin
                if (cleanup_enable_reg)
                begin
                    mul_start  = 1'b1;
                    mul_a      = hp_mag;
                    mul_b      = MUL_B_W'(dc_coeff_reg);
                    neg_next   = hp_prev_output_reg[SLOT_W-1];
                    state_next = ST_HP_MUL;
                end
                else
                begin
                    result_next = faded_reg;
                    state_next  = ST_OUT;
                end
            end

            ST_HP_MUL:
            begin
                if (mul_done)
                begin
                    div_req.start = 1'b1;
                    div_req.len   = DIV_LEN_W'(HPROD_W);
                    div_dividend  = {mul_product[HPROD_W-1:0], {(DIV_N_W-HPROD_W){1'b0}}};
                    div_divisor   = Q15_ONE;
                    state_next    = ST_HP_DIV;
                end
            end

            ST_HP_DIV:
            begin
                if (div_done)
                begin
                    term_next  = neg_reg ? $signed((SLOT_W+1)'(0) - q33) : $signed(q33);
                    state_next = ST_HP_SUM;
                end
            end

            ST_HP_SUM:
            begin
                hp_prev_output_next = sat32(hp_sum);
                hp_prev_input_next  = faded_reg;
                state_next          = ST_LP_START;
            end

            ST_LP_START:
            begin
                div_req.start = 1'b1;
                div_req.len   = DIV_LEN_W'(LPMAG_W);
                div_dividend  = {lp_mag, {(DIV_N_W-LPMAG_W){1'b0}}};
                div_divisor   = lp_div;
                neg_next      = lp_diff[SLOT_W];
                state_next    = ST_LP_DIV;
            end

            ST_LP_DIV:
            begin
                if (div_done)
                begin
                    step_next  = neg_reg ? $signed((SLOT_W+2)'(0) - q34) : $signed(q34);
                    state_next = ST_LP_SUM;
                end
            end

            ST_LP_SUM:
            begin
                lp_prev_output_next = sat32(lp_sum);
                state_next          = ST_GATE;
            end

            ST_GATE:
            begin
                result_next = gated;
                state_next  = ST_OUT;
            end

            ST_OUT:
            begin
                // output register free or emptying this cycle
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = result_reg;
                    out_last_next   = clip_end_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------------
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    // both slots carry the sample in their upper half
    assign m_axis_tdata  = {out_sample_reg, {(SLOT_W-SAMPLE_W){1'b0}},
                            out_sample_reg, {(SLOT_W-SAMPLE_W){1'b0}}};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // a unit result never arrives unclaimed
    a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!div_done && !mul_done))
        else $error("serial unit finished while sequencer idle");

    // a pending result is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && m_axis_tvalid && !m_axis_tready) |=> (state_reg == ST_OUT))
        else $error("result left output stage while output register full");

    // an accepted item starts the window checks
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_CHECK))
        else $error("accepted item did not enter processing");

    // first-of-clip clears the filter history
    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0])
        |=> (hp_prev_input_reg == '0 && hp_prev_output_reg == '0
             && lp_prev_output_reg == '0 && idx_reg == '0))
        else $error("first-of-clip did not clear filter state");

endmodule
